/* design/ltl_pkg.sv */
// Shared types and arithmetic for the LSP to LPC conversion block.
`default_nettype none
package ltl_pkg;

  localparam int unsigned NumCoef = 5;
  localparam int unsigned NumPoly = 11;
  localparam int unsigned NumLpc  = 10;
  localparam int unsigned NumStep = 4;

  localparam logic [31:0] OneQ22   = 32'h0040_0000;
  localparam logic [47:0] RoundMul = 48'h0000_0000_2000;
  localparam logic [31:0] RoundOut = 32'h0000_1000;
  localparam logic [10:0] LpcOne   = 11'h400;

  typedef logic [NumPoly-1:0][31:0] poly_t;
  typedef logic [NumCoef-1:0][15:0] coef_t;
  typedef logic [NumLpc-1:0][15:0]  lpc_t;

  function automatic logic [31:0] scale_k(logic [15:0] k);
    return {{8{k[15]}}, k, 8'h00};
  endfunction

  function automatic logic [31:0] mul_round(logic [31:0] a, logic [15:0] k);
    logic signed [47:0] prod;
    logic [47:0] sum;
    prod = $signed(a) * $signed(k);
    sum  = 48'(prod) + RoundMul;
    return sum[45:14];
  endfunction

  function automatic poly_t poly_init(logic [15:0] c0);
    poly_t p;
    p    = '0;
    p[0] = OneQ22;
    p[1] = 32'h0 - scale_k(c0);
    p[2] = OneQ22;
    return p;
  endfunction

  // One step of the recurrence; every new term but the top one, which is set to one, is formed from the old ones.
  function automatic poly_t poly_step(poly_t p, logic [15:0] k, int i);
    poly_t n;
    n = p;
    n[i+3] = p[i+1] - scale_k(k);
    n[i+4] = OneQ22;
    for (int t = 2; t < NumPoly; t++) begin
      if (t <= i + 2) begin
        n[t] = p[t] - mul_round(p[t-1], k) + p[t-2];
      end
    end
    n[1] = p[1] - scale_k(k);
    return n;
  endfunction

endpackage
`default_nettype wire

/* design/ltl_lane.sv */
// Pipelined expansion of five coefficients into one 11-term polynomial.
`default_nettype none
module ltl_lane (
  input  wire logic                        clk_i,
  input  wire logic [ltl_pkg::NumStep:0]   en_i,
  input  wire ltl_pkg::coef_t              coef_i,
  output ltl_pkg::poly_t                   poly_o
);

  ltl_pkg::poly_t p_q [ltl_pkg::NumStep+1];
  ltl_pkg::coef_t k_q [ltl_pkg::NumStep];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q[0] <= ltl_pkg::poly_init(coef_i[0]);
      k_q[0] <= coef_i;
    end
  end

  for (genvar s = 1; s <= ltl_pkg::NumStep; s++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        p_q[s] <= ltl_pkg::poly_step(p_q[s-1], k_q[s-1][s], 2 * (s - 1));
      end
    end
    if (s < ltl_pkg::NumStep) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          k_q[s] <= k_q[s-1];
        end
      end
    end
  end

  assign poly_o = p_q[ltl_pkg::NumStep];

endmodule
`default_nettype wire

/* design/ltl_merge.sv */
// Combines the even and odd polynomials into the registered predictor set.
`default_nettype none
module ltl_merge (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire ltl_pkg::poly_t even_i,
  input  wire ltl_pkg::poly_t odd_i,
  output ltl_pkg::lpc_t       lpc_o
);

  ltl_pkg::lpc_t lpc_d, lpc_q;

  always_comb begin
    logic [31:0] s;
    for (int i = 0; i < ltl_pkg::NumLpc; i++) begin
      s = even_i[i] + even_i[i+1] + odd_i[i+1] - odd_i[i] + ltl_pkg::RoundOut;
      lpc_d[i] = s[28:13];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lpc_q <= lpc_d;
    end
  end

  assign lpc_o = lpc_q;

endmodule
`default_nettype wire

/* design/lsp_to_lpc_conversion.sv */
// Top level of the order-10 LSP to LPC conversion pipeline.
// Throughput: one item per cycle while the output is not stalled; an init stage, four
// recurrence stages per lane and a merge register, through which a transfer passes to the
// result. Each stage holds its item only while the stage after it is full and stalled.
// Reset clears the stage valid bits; data registers are not reset.
`default_nettype none
module lsp_to_lpc_conversion (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] lsp_0_i,
  input  wire logic signed [15:0] lsp_1_i,
  input  wire logic signed [15:0] lsp_2_i,
  input  wire logic signed [15:0] lsp_3_i,
  input  wire logic signed [15:0] lsp_4_i,
  input  wire logic signed [15:0] lsp_5_i,
  input  wire logic signed [15:0] lsp_6_i,
  input  wire logic signed [15:0] lsp_7_i,
  input  wire logic signed [15:0] lsp_8_i,
  input  wire logic signed [15:0] lsp_9_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic        [10:0]      lpc_0_o,
  output logic signed [15:0]      lpc_1_o,
  output logic signed [15:0]      lpc_2_o,
  output logic signed [15:0]      lpc_3_o,
  output logic signed [15:0]      lpc_4_o,
  output logic signed [15:0]      lpc_5_o,
  output logic signed [15:0]      lpc_6_o,
  output logic signed [15:0]      lpc_7_o,
  output logic signed [15:0]      lpc_8_o,
  output logic signed [15:0]      lpc_9_o,
  output logic signed [15:0]      lpc_10_o
);

  localparam int unsigned Last = ltl_pkg::NumStep + 1;

  logic [Last:0] v_q, v_d, en;
  ltl_pkg::coef_t even_c, odd_c;
  ltl_pkg::poly_t even_p, odd_p;
  ltl_pkg::lpc_t  lpc;

  always_comb begin
    en[Last] = !v_q[Last] || out_ready_i;
    for (int s = Last - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int s = 1; s <= Last; s++) begin
      if (en[s]) begin
        v_d[s] = v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign even_c = {lsp_8_i, lsp_6_i, lsp_4_i, lsp_2_i, lsp_0_i};
  assign odd_c  = {lsp_9_i, lsp_7_i, lsp_5_i, lsp_3_i, lsp_1_i};

  ltl_lane u_even (
    .clk_i  (clk_i),
    .en_i   (en[ltl_pkg::NumStep:0]),
    .coef_i (even_c),
    .poly_o (even_p)
  );

  ltl_lane u_odd (
    .clk_i  (clk_i),
    .en_i   (en[ltl_pkg::NumStep:0]),
    .coef_i (odd_c),
    .poly_o (odd_p)
  );

  ltl_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en[Last]),
    .even_i (even_p),
    .odd_i  (odd_p),
    .lpc_o  (lpc)
  );

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[Last];
  assign lpc_0_o     = ltl_pkg::LpcOne;
  assign lpc_1_o     = lpc[0];
  assign lpc_2_o     = lpc[1];
  assign lpc_3_o     = lpc[2];
  assign lpc_4_o     = lpc[3];
  assign lpc_5_o     = lpc[4];
  assign lpc_6_o     = lpc[5];
  assign lpc_7_o     = lpc[6];
  assign lpc_8_o     = lpc[7];
  assign lpc_9_o     = lpc[8];
  assign lpc_10_o    = lpc[9];

`ifndef NO_ASSERTIONS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("Accepted transfer did not enter the first stage.");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input stalled while the output stage was empty.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lpc))
    else $error("Stalled result changed.");
`endif

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the order-10 LSP to LPC conversion block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [10:0]   lead;
    ltl_pkg::lpc_t coef;
  } lpc_set_t;

  class lpc_scoreboard;
    lpc_set_t pending[$];
    int       errors;
    int       matched;

    function automatic logic [31:0] round_mul14(logic [31:0] a, logic [31:0] c);
      logic signed [63:0] prod;
      logic [63:0]        sum;
      prod = $signed({{32{a[31]}}, a}) * $signed({{32{c[31]}}, c});
      sum  = 64'(prod) + 64'h2000;
      return sum[45:14];
    endfunction

    function automatic void expand_poly(output logic [31:0] p[11], input logic [31:0] c[5]);
      logic [31:0] k;
      int t;
      p[0] = ltl_pkg::OneQ22;
      p[1] = 32'h0 - c[0] * 32'h100;
      p[2] = ltl_pkg::OneQ22;
      for (int i = 0; i < 8; i += 2) begin
        k = c[i/2+1];
        p[i+3] = p[i+1] - k * 32'h100;
        p[i+4] = ltl_pkg::OneQ22;
        for (int j = 0; j < i + 1; j++) begin
          t = i - j + 2;
          p[t] = p[t] - round_mul14(p[t-1], k);
          p[t] = p[t] + p[t-2];
        end
        p[1] = p[1] - round_mul14(ltl_pkg::OneQ22, k);
      end
    endfunction

    function automatic void note_input(logic [15:0] lsp[10]);
      logic [31:0] ev[5], od[5], e[11], o[11], s;
      lpc_set_t exp_set;
      for (int i = 0; i < 5; i++) begin
        ev[i] = {{16{lsp[2*i][15]}}, lsp[2*i]};
        od[i] = {{16{lsp[2*i+1][15]}}, lsp[2*i+1]};
      end
      expand_poly(e, ev);
      expand_poly(o, od);
      exp_set.lead = 11'd1024;
      for (int i = 0; i < 10; i++) begin
        s = e[i] + e[i+1] + o[i+1] - o[i] + ltl_pkg::RoundOut;
        exp_set.coef[i] = s[28:13];
      end
      pending.push_back(exp_set);
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(lpc_set_t got);
      lpc_set_t want;
      if (pending.size() == 0) begin
        report("result transfer with no expected coefficient set");
        return;
      end
      want = pending.pop_front();
      matched++;
      if (got.lead !== want.lead)
        report($sformatf("lpc_0 got %0d want %0d", got.lead, want.lead));
      for (int i = 0; i < 10; i++)
        if (got.coef[i] !== want.coef[i])
          report($sformatf("lpc_%0d got %h want %h", i + 1, got.coef[i], want.coef[i]));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic [15:0] lsp[10];
  logic in_ready_o, out_valid_o;
  logic [10:0] lpc_0_o;
  logic [15:0] lpc_o[1:10];
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  lpc_scoreboard sb = new();

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lsp_to_lpc_conversion u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o,
    .lsp_0_i(lsp[0]), .lsp_1_i(lsp[1]), .lsp_2_i(lsp[2]), .lsp_3_i(lsp[3]),
    .lsp_4_i(lsp[4]), .lsp_5_i(lsp[5]), .lsp_6_i(lsp[6]), .lsp_7_i(lsp[7]),
    .lsp_8_i(lsp[8]), .lsp_9_i(lsp[9]),
    .out_valid_o, .out_ready_i(out_ready), .lpc_0_o,
    .lpc_1_o(lpc_o[1]), .lpc_2_o(lpc_o[2]), .lpc_3_o(lpc_o[3]), .lpc_4_o(lpc_o[4]),
    .lpc_5_o(lpc_o[5]), .lpc_6_o(lpc_o[6]), .lpc_7_o(lpc_o[7]), .lpc_8_o(lpc_o[8]),
    .lpc_9_o(lpc_o[9]), .lpc_10_o(lpc_o[10])
  );

  initial for (int i = 0; i < 10; i++) lsp[i] = '0;

  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    lpc_set_t got;
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.note_input(lsp);
      if (out_valid_o && out_ready) begin
        got.lead = lpc_0_o;
        for (int i = 0; i < 10; i++) got.coef[i] = lpc_o[i+1];
        sb.check_result(got);
      end
    end
  end

  task send_set(logic [15:0] v[10]);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    for (int i = 0; i < 10; i++) lsp[i] <= v[i];
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_field(int mode);
    case (mode)
      0: return 16'($urandom);
      1: case ($urandom_range(4))
           0: return 16'h8000;
           1: return 16'h7fff;
           2: return 16'h0000;
           3: return 16'hffff;
           default: return 16'($urandom);
         endcase
      default: return 16'($signed($urandom_range(4096)) - 2048);
    endcase
  endfunction

  task random_sets(int n, int idle, int stall);
    logic [15:0] v[10];
    int mode;
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) begin
      mode = $urandom_range(2);
      for (int i = 0; i < 10; i++) v[i] = pick_field(mode);
      send_set(v);
    end
  endtask

  initial begin
    logic [15:0] v[10];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int d = 0; d < 20; d++) begin
      for (int i = 0; i < 10; i++)
        case (d % 5)
          0: v[i] = 16'h8000;
          1: v[i] = 16'h7fff;
          2: v[i] = (i % 2) ? 16'h7fff : 16'h8000;
          3: v[i] = (d == 3) ? 16'h0000 : 16'hffff;
          default: v[i] = (i == d / 5) ? 16'h8000 : 16'h4000;
        endcase
      send_set(v);
    end
    random_sets(360, 0, 0);
    random_sets(360, 78, 0);
    random_sets(360, 0, 78);
    random_sets(360, 27, 27);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d coefficient sets, %0d results checked, %0d mismatches.",
             sent, sb.matched, sb.errors);
    $display("Covered extreme fields and four sender/receiver idle mixes.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("lsp_to_lpc_conversion regression: pass");
    end else begin
      $display("lsp_to_lpc_conversion regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("lsp_to_lpc_conversion regression: fail");
    $finish;
  end
endmodule
